FILE: rtl/rfr_pkg.sv
// ----------------------------------------------------------------------------
// rfr_pkg: shared types and constants of the response frame receiver
// Parser phases, status codes, queue entry and result records, and the
// NAK code lookup.
// ----------------------------------------------------------------------------
package rfr_pkg;

  // queue between classifier and parser
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QAW    = $clog2(QDEPTH);
  localparam int unsigned QCW    = $clog2(QDEPTH + 1);

  localparam logic [7:0] ACK_RESET = 8'h06;

  // parser phase
  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_NAKERR = 3'd1,
    PH_LEN    = 3'd2,
    PH_BODY   = 3'd3,
    PH_SUM    = 3'd4
  } phase_e;

  // end of frame status
  typedef enum logic [2:0] {
    ST_ACK     = 3'd0,
    ST_NAK     = 3'd1,
    ST_OK      = 3'd2,
    ST_EMPTY   = 3'd3,
    ST_CSUM    = 3'd4,
    ST_TIMEOUT = 3'd5
  } status_e;

  // result kind
  localparam logic KIND_BODY = 1'b0;
  localparam logic KIND_END  = 1'b1;

  // classified receive attempt
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       timeout;
    logic       is_ack;
    logic       is_nak;
  } item_t;

  // one result
  typedef struct packed {
    logic       out_kind;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic [7:0] response_code;
    logic [7:0] body_length;
    logic       last;
  } result_t;

  localparam int unsigned NAK_NUM = 13;
  localparam logic [7:0] NAK_CODES [NAK_NUM] = '{
    8'h80, 8'h90, 8'h91, 8'hbf, 8'hc0, 8'hc2, 8'hc3,
    8'hc8, 8'hcc, 8'hcd, 8'hd0, 8'hd2, 8'hd8
  };

  // true when the byte is one of the negative acknowledge codes
  function automatic logic is_nak_code(input logic [7:0] b);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < NAK_NUM; i++) begin
      if (NAK_CODES[i] == b) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

FILE: rtl/response_frame_receiver_unit.sv
// ----------------------------------------------------------------------------
// response_frame_receiver_unit: response frame parser
// Parses ack, nak and length-prefixed frames from a received byte stream,
// passes body bytes through and closes each frame with a status.
//
// channel     direction  contents
// s_axis_*    in         tdata rx_byte, tuser timeout
// m_axis_*    out        tdata byte/status/code/length, tuser kind, tlast
// cfg_*       in         ack code write
//
// one receive attempt per cycle while the queue has room; the classifier is
// combinational, so an accepted transaction is written into the two-entry
// queue and, once at its head and not stalled, parsed into the output register
// reset returns the parser to idle and the ack code to 0x06
// a stalled output fills the queue, then drops s_axis_tready
// ----------------------------------------------------------------------------
module response_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic        s_axis_tuser,   // [0] timeout
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [7:0] out_byte, [10:8] status,
                                      // [18:11] response_code,
                                      // [26:19] body_length, [31:27] zero
  output logic        m_axis_tuser,   // [0] out_kind
  output logic        m_axis_tlast
);
  import rfr_pkg::*;

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  item_t   push_item;
  item_t   head;
  result_t res;

  // classifier
  rfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_byte_i    (s_axis_tdata),
    .in_timeout_i (s_axis_tuser),
    .q_full_i     (q_full),
    .in_ready_o   (s_axis_tready),
    .push_o       (push),
    .push_item_o  (push_item)
  );

  // decoupling queue
  rfr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .empty_o     (q_empty),
    .head_o      (head)
  );

  // parser
  rfr_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .head_i      (head),
    .pop_o       (pop),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res)
  );

  // output packing
  assign m_axis_tdata = {5'd0, res.body_length, res.response_code, res.status, res.out_byte};
  assign m_axis_tuser = res.out_kind;
  assign m_axis_tlast = res.last;

endmodule

FILE: rtl/rfr_front.sv
// ----------------------------------------------------------------------------
// rfr_front: input side classifier
// Accepts receive attempts and tags each byte as ack code or nak code
// before it enters the queue.
// ----------------------------------------------------------------------------
module rfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [7:0]      cfg_data_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_timeout_i,
  input  logic            q_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output rfr_pkg::item_t  push_item_o
);
  import rfr_pkg::*;

  logic [7:0] ack_code_q;

  // acknowledge code register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ack_code_q <= ACK_RESET;
    end else if (cfg_we_i) begin
      ack_code_q <= cfg_data_i;
    end
  end

  // accept whenever the queue has room
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // classify the byte
  always_comb begin
    push_item_o.rx_byte = in_byte_i;
    push_item_o.timeout = in_timeout_i;
    push_item_o.is_ack  = (in_byte_i == ack_code_q);
    push_item_o.is_nak  = is_nak_code(in_byte_i);
  end

endmodule

FILE: rtl/rfr_queue.sv
// ----------------------------------------------------------------------------
// rfr_queue: small queue of classified items
// Decouples the classifier from the parser so either can stall alone.
// ----------------------------------------------------------------------------
module rfr_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  rfr_pkg::item_t  push_item_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output rfr_pkg::item_t  head_o
);
  import rfr_pkg::*;

  item_t          mem_q [QDEPTH];
  logic [QAW-1:0] wptr_q, wptr_d;
  logic [QAW-1:0] rptr_q, rptr_d;
  logic [QCW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCW'(QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rptr_q];

  // pointer and count update
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push_i) begin
      wptr_d = (wptr_q == QAW'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (pop_i) begin
      rptr_d = (rptr_q == QAW'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/rfr_parse.sv
// ----------------------------------------------------------------------------
// rfr_parse: frame parser and result register
// Walks the frame phases one item per cycle while not stalled, keeps the
// running sum and holds each result in an output register until taken.
// ----------------------------------------------------------------------------
module rfr_parse (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  rfr_pkg::item_t    head_i,
  output logic              pop_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output rfr_pkg::result_t  out_res_o
);
  import rfr_pkg::*;

  phase_e     phase_q, phase_d;
  logic [7:0] code_q, code_d;
  logic [7:0] len_q, len_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic       out_vld_q, out_vld_d;
  result_t    res_q, res_d;

  logic       emit;
  result_t    res;
  logic [7:0] sum_add;
  logic [7:0] left_dec;

  // take an item when the result register is free or being drained
  assign pop_o    = !q_empty_i && (!out_vld_q || out_ready_i);
  assign sum_add  = sum_q + head_i.rx_byte;
  assign left_dec = left_q - 8'd1;

  // next phase
  always_comb begin
    phase_d = phase_q;
    if (pop_o) begin
      if (head_i.timeout) begin
        phase_d = PH_IDLE;
      end else begin
        unique case (phase_q)
          PH_NAKERR: phase_d = PH_IDLE;
          PH_LEN:    phase_d = (head_i.rx_byte == 8'd0) ? PH_SUM : PH_BODY;
          PH_BODY:   phase_d = (left_dec == 8'd0) ? PH_SUM : PH_BODY;
          PH_SUM:    phase_d = PH_IDLE;
          default: begin
            if (head_i.is_ack) begin
              phase_d = PH_IDLE;
            end else if (head_i.is_nak) begin
              phase_d = PH_NAKERR;
            end else begin
              phase_d = PH_LEN;
            end
          end
        endcase
      end
    end
  end

  // frame registers and result
  always_comb begin
    code_d = code_q;
    len_d  = len_q;
    left_d = left_q;
    sum_d  = sum_q;
    emit   = 1'b0;
    res    = '0;
    if (pop_o) begin
      if (head_i.timeout) begin
        emit              = 1'b1;
        res.out_kind      = KIND_END;
        res.status        = ST_TIMEOUT;
        res.last          = 1'b1;
        res.response_code = (phase_q inside {PH_NAKERR, PH_LEN, PH_BODY, PH_SUM})
                            ? code_q : 8'd0;
        res.body_length   = (phase_q inside {PH_BODY, PH_SUM}) ? len_q : 8'd0;
      end else begin
        unique case (phase_q)
          PH_NAKERR: begin
            emit              = 1'b1;
            res.out_kind      = KIND_END;
            res.out_byte      = head_i.rx_byte;
            res.status        = ST_NAK;
            res.response_code = code_q;
            res.last          = 1'b1;
          end
          PH_LEN: begin
            len_d  = head_i.rx_byte;
            left_d = head_i.rx_byte;
            sum_d  = sum_add;
          end
          PH_BODY: begin
            sum_d             = sum_add;
            left_d            = left_dec;
            emit              = 1'b1;
            res.out_kind      = KIND_BODY;
            res.out_byte      = head_i.rx_byte;
            res.response_code = code_q;
            res.body_length   = len_q;
          end
          PH_SUM: begin
            sum_d             = sum_add;
            emit              = 1'b1;
            res.out_kind      = KIND_END;
            res.response_code = code_q;
            res.last          = 1'b1;
            if (len_q == 8'd0) begin
              res.status = ST_EMPTY;
            end else begin
              res.status      = (sum_add == 8'd0) ? ST_OK : ST_CSUM;
              res.body_length = len_q;
            end
          end
          default: begin
            code_d = head_i.rx_byte;
            len_d  = 8'd0;
            left_d = 8'd0;
            if (head_i.is_ack) begin
              emit              = 1'b1;
              res.out_kind      = KIND_END;
              res.status        = ST_ACK;
              res.response_code = head_i.rx_byte;
              res.last          = 1'b1;
            end else if (!head_i.is_nak) begin
              sum_d = head_i.rx_byte;
            end
          end
        endcase
      end
    end
  end

  // result register update
  always_comb begin
    out_vld_d = out_vld_q;
    res_d     = res_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (emit) begin
      out_vld_d = 1'b1;
      res_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      code_q    <= '0;
      len_q     <= '0;
      left_q    <= '0;
      sum_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      phase_q   <= phase_d;
      code_q    <= code_d;
      len_q     <= len_d;
      left_q    <= left_d;
      sum_q     <= sum_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = res_q;

endmodule

FILE: dv/tb.sv
// ----------------------------------------------------------------------------
// tb: stream-level testbench of the response frame receiver
// Sends ack, nak and length-prefixed frames, broken frames, stray bytes
// and receive timeouts under several ack code settings. A frame parser
// model predicts every body byte and frame status, and a scoreboard
// compares them in order with the output stream while both sides of the
// block idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NAK_COUNT    = 13;
  localparam logic [7:0] NAK_LIST [NAK_COUNT] = '{
    8'h80, 8'h90, 8'h91, 8'hbf, 8'hc0, 8'hc2, 8'hc3,
    8'hc8, 8'hcc, 8'hcd, 8'hd0, 8'hd2, 8'hd8
  };

  // output stall patterns
  localparam int SINK_ALWAYS   = 0;
  localparam int SINK_RANDOM   = 1;
  localparam int SINK_PERIODIC = 2;

  // frame parser model and in-order result scoreboard
  class frame_tracker;
    logic [7:0] ack_code;
    phase_e     phase;
    logic [7:0] frame_code;
    logic [7:0] frame_length;
    logic [7:0] bytes_left;
    logic [7:0] running_sum;
    result_t    due_results[$];
    int         errors;
    int         rx_seen;
    int         body_seen;
    int         ends_seen[6];

    function new();
      ack_code     = ACK_RESET;
      phase        = PH_IDLE;
      frame_code   = '0;
      frame_length = '0;
      bytes_left   = '0;
      running_sum  = '0;
      errors       = 0;
      rx_seen      = 0;
      body_seen    = 0;
      foreach (ends_seen[i]) ends_seen[i] = 0;
    endfunction

    function bit nak_code(logic [7:0] b);
      foreach (NAK_LIST[i]) begin
        if (NAK_LIST[i] == b) return 1'b1;
      end
      return 1'b0;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    // advance the parser by one receive attempt, queue what it produces
    function void note_rx(logic [7:0] b, logic to);
      result_t r;
      bit      hit;
      r   = '0;
      hit = 1'b0;
      rx_seen++;
      if (to) begin
        r.out_kind = KIND_END;
        r.status   = ST_TIMEOUT;
        r.last     = 1'b1;
        if (phase != PH_IDLE) begin
          r.response_code = frame_code;
          if (phase == PH_BODY || phase == PH_SUM) r.body_length = frame_length;
        end
        phase = PH_IDLE;
        hit   = 1'b1;
      end else begin
        case (phase)
          PH_NAKERR: begin
            r.out_kind      = KIND_END;
            r.out_byte      = b;
            r.status        = ST_NAK;
            r.response_code = frame_code;
            r.last          = 1'b1;
            phase           = PH_IDLE;
            hit             = 1'b1;
          end
          PH_LEN: begin
            frame_length = b;
            bytes_left   = b;
            running_sum  = running_sum + b;
            phase        = (b == 8'd0) ? PH_SUM : PH_BODY;
          end
          PH_BODY: begin
            running_sum     = running_sum + b;
            bytes_left      = bytes_left - 8'd1;
            if (bytes_left == 8'd0) phase = PH_SUM;
            r.out_kind      = KIND_BODY;
            r.out_byte      = b;
            r.response_code = frame_code;
            r.body_length   = frame_length;
            hit             = 1'b1;
          end
          PH_SUM: begin
            running_sum     = running_sum + b;
            r.out_kind      = KIND_END;
            r.response_code = frame_code;
            r.last          = 1'b1;
            if (frame_length == 8'd0) begin
              r.status = ST_EMPTY;
            end else begin
              r.status      = (running_sum == 8'd0) ? ST_OK : ST_CSUM;
              r.body_length = frame_length;
            end
            phase = PH_IDLE;
            hit   = 1'b1;
          end
          default: begin
            frame_code   = b;
            frame_length = '0;
            bytes_left   = '0;
            if (b == ack_code) begin
              r.out_kind      = KIND_END;
              r.status        = ST_ACK;
              r.response_code = b;
              r.last          = 1'b1;
              phase           = PH_IDLE;
              hit             = 1'b1;
            end else if (nak_code(b)) begin
              phase = PH_NAKERR;
            end else begin
              running_sum = b;
              phase       = PH_LEN;
            end
          end
        endcase
      end
      if (hit) due_results.push_back(r);
    endfunction

    function void cmp_field(string what, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
      end
    endfunction

    // compare one output transaction with the oldest prediction
    function void check_result(logic [31:0] data, logic kind, logic lst);
      result_t want;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, tdata %h tuser %b tlast %b",
                 $time, data, kind, lst);
        return;
      end
      want = due_results.pop_front();
      cmp_field("out_kind", 8'(want.out_kind), 8'(kind));
      cmp_field("out_byte", want.out_byte, data[7:0]);
      cmp_field("status", 8'(want.status), 8'(data[10:8]));
      cmp_field("response_code", want.response_code, data[18:11]);
      cmp_field("body_length", want.body_length, data[26:19]);
      cmp_field("tdata padding", 8'd0, 8'(data[31:27]));
      cmp_field("last", 8'(want.last), 8'(lst));
      if (want.out_kind == KIND_BODY) body_seen++;
      else if (want.status < 6) ends_seen[want.status]++;
    endfunction
  endclass

  typedef struct {
    logic [7:0] rx_byte;
    logic       timeout;
    bit         drain_first;
  } rx_attempt_t;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [7:0]  cfg_data_i    = 8'd0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = 8'd0;   // [7:0] rx_byte
  logic        s_axis_tuser  = 1'b0;   // [0] timeout
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;           // [7:0] out_byte, [10:8] status,
                                       // [18:11] response_code,
                                       // [26:19] body_length, [31:27] zero
  logic        m_axis_tuser;           // [0] out_kind
  logic        m_axis_tlast;

  frame_tracker sb;
  rx_attempt_t  rx_plan[$];
  int           sink_mode = SINK_ALWAYS;
  bit           gappy     = 1'b0;
  int           cycle_cnt = 0;
  int           stall_cnt = 0;
  int           hold_left = 0;
  logic [7:0]   ack_values[5];

  response_frame_receiver_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // output backpressure
  always @(posedge clk_i) begin
    stall_cnt <= stall_cnt + 1;
    case (sink_mode)
      SINK_ALWAYS: m_axis_tready <= 1'b1;
      SINK_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 70);
      default: begin
        if (hold_left > 0) begin
          hold_left     <= hold_left - 1;
          m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 63) == 0) begin
          hold_left     <= $urandom_range(8, 30);
          m_axis_tready <= 1'b0;
        end else begin
          m_axis_tready <= (stall_cnt % 9) < 5;
        end
      end
    endcase
  end

  // transaction monitors on both sides
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_rx(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
  end

  function automatic void push_rx(logic [7:0] b, logic to);
    rx_plan.push_back('{rx_byte: b, timeout: to, drain_first: 1'b0});
  endfunction

  // command frame; a timeout replaces the item at position cut (code is 0)
  function automatic void add_cmd_frame(logic [7:0] code, logic [7:0] len, bit good_sum,
                                        int cut);
    logic [7:0] sum;
    logic [7:0] b;
    int         n;
    n   = len;
    sum = code;
    push_rx(code, 1'b0);
    for (int k = 1; k <= n + 2; k++) begin
      if (k == cut) begin
        push_rx(8'($urandom), 1'b1);
        return;
      end
      if (k == 1) b = len;
      else if (k <= n + 1) b = 8'($urandom);
      else b = good_sum ? 8'(8'd0 - sum) : 8'($urandom);
      sum = sum + b;
      push_rx(b, 1'b0);
    end
  endfunction

  // edge cases under the reset ack code
  function automatic void plan_directed();
    push_rx(8'h06, 1'b0);                       // ack
    push_rx(8'h80, 1'b0);                       // nak with all-ones error byte
    push_rx(8'hff, 1'b0);
    push_rx(8'h91, 1'b0);                       // nak with zero error byte
    push_rx(8'h00, 1'b0);
    add_cmd_frame(8'h01, 8'd0, 1'b0, -1);       // empty body, sum not checked
    push_rx(8'hff, 1'b0);                       // good sum, extreme body bytes
    push_rx(8'h02, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'hff, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'h10, 1'b0);                       // bad sum
    push_rx(8'h01, 1'b0);
    push_rx(8'h20, 1'b0);
    push_rx(8'h00, 1'b0);
    push_rx(8'($urandom), 1'b1);                // timeout while idle
    add_cmd_frame(8'h33, 8'd4, 1'b1, 1);        // timeout in place of length
    add_cmd_frame(8'h34, 8'd3, 1'b1, 3);        // timeout inside the body
    add_cmd_frame(8'h35, 8'd0, 1'b1, 2);        // timeout in place of checksum
    push_rx(8'hd8, 1'b0);                       // timeout in place of nak error
    push_rx(8'hff, 1'b1);
  endfunction

  // mostly well-formed frames, some noise, cut frames and drain points
  function automatic void plan_random(int n_items);
    int         pick;
    int         start;
    int         len;
    int         cut;
    int         stop;
    bit         hold;
    logic [7:0] code;
    stop = rx_plan.size() + n_items;
    while (rx_plan.size() < stop) begin
      start = rx_plan.size();
      hold  = ($urandom_range(0, 24) == 0);
      pick  = $urandom_range(0, 99);
      if (pick < 8) begin
        push_rx(sb.ack_code, 1'b0);
      end else if (pick < 18) begin
        push_rx(NAK_LIST[$urandom_range(0, NAK_COUNT - 1)], 1'b0);
        push_rx(8'($urandom), $urandom_range(0, 9) == 0);
      end else if (pick < 25) begin
        repeat ($urandom_range(1, 3)) push_rx(8'($urandom), $urandom_range(0, 4) == 0);
      end else begin
        do code = 8'($urandom); while (code == sb.ack_code || sb.nak_code(code));
        pick = $urandom_range(0, 199);
        if (pick < 30) len = 0;
        else if (pick < 170) len = $urandom_range(1, 6);
        else if (pick < 196) len = $urandom_range(7, 40);
        else len = $urandom_range(200, 255);
        cut = ($urandom_range(0, 11) == 0) ? $urandom_range(1, len + 2) : -1;
        add_cmd_frame(code, 8'(len), $urandom_range(0, 3) != 0, cut);
      end
      if (hold) rx_plan[start].drain_first = 1'b1;
    end
  endfunction

  // send the planned attempts in bursts
  task automatic play_rx_plan();
    rx_attempt_t it;
    int          burst;
    burst = $urandom_range(1, 20);
    while (rx_plan.size() > 0) begin
      it = rx_plan.pop_front();
      if (it.drain_first) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (sb.pending() != 0);
      end
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= it.rx_byte;
      s_axis_tuser  <= it.timeout;
      do @(posedge clk_i); while (!s_axis_tready);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 20);
        if (gappy) begin
          s_axis_tvalid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk_i);
        end
      end
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // wait for all results, then let frames without results clear the pipeline
  task automatic settle();
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ack(logic [7:0] value);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.ack_code = value;
  endtask

  // main sequence
  initial begin
    sb = new();
    ack_values = '{8'hff, 8'h00, 8'h80, 8'($urandom), 8'h06};
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    sink_mode = SINK_RANDOM;
    gappy     = 1'b1;
    plan_directed();
    play_rx_plan();

    foreach (ack_values[i]) begin
      settle();
      write_ack(ack_values[i]);
      sink_mode = (i == 0) ? SINK_ALWAYS : $urandom_range(SINK_ALWAYS, SINK_PERIODIC);
      gappy     = (i != 0);
      plan_random(95);
      play_rx_plan();
    end
    settle();

    $display("covered %0d receive attempts, %0d body bytes, ends: ack %0d nak %0d ok %0d",
             sb.rx_seen, sb.body_seen, sb.ends_seen[ST_ACK], sb.ends_seen[ST_NAK],
             sb.ends_seen[ST_OK]);
    $display("empty %0d, checksum error %0d, timeout %0d; ack codes 06 ff 00 80 %02h 06",
             sb.ends_seen[ST_EMPTY], sb.ends_seen[ST_CSUM], sb.ends_seen[ST_TIMEOUT],
             ack_values[3]);
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
